// ===== hdl/lcfp_pkg.sv =====
// lcfp_pkg: shared types and constants for the led command frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package lcfp_pkg;

  localparam int FRAME_LEN   = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] HDR_FIRST      = 8'h55;
  localparam logic [7:0] HDR_SECOND     = 8'hAA;
  localparam logic [7:0] FUNC_LED_WRITE = 8'h06;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  localparam logic [2:0] ST_LED_WRITE = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_OTHER     = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] func_code;
    logic [7:0] led_index;
    logic       led_on;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== hdl/lcfp_front.sv =====
// lcfp_front: accepts receive events, fills the frame store, classifies a frame on idle
// depends on lcfp_pkg; pushes one result into lcfp_queue per idle event
`default_nettype none

module lcfp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             op,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             queue_full,
  output logic                  push,
  output lcfp_pkg::result_t     push_data
);
  import lcfp_pkg::*;

  logic [2:0] byte_count;
  logic [7:0] frame_store [FRAME_LEN];
  logic       accept;
  logic [7:0] sum;
  result_t    res;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (op == OP_IDLE) begin
        byte_count <= '0;
      end else if (byte_count < 3'(FRAME_LEN)) begin
        byte_count <= byte_count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_BYTE && byte_count < 3'(FRAME_LEN)) begin
      frame_store[byte_count] <= rx_byte;
    end
  end

  assign sum = frame_store[0] ^ frame_store[1] ^ frame_store[2]
             ^ frame_store[3] ^ frame_store[4];

  always_comb begin
    res = '0;
    if (byte_count != 3'(FRAME_LEN)) begin
      res.status = ST_BAD_LEN;
    end else if (frame_store[0] != HDR_FIRST || frame_store[1] != HDR_SECOND) begin
      res.status = ST_BAD_HDR;
    end else if (sum != frame_store[5]) begin
      res.status = ST_BAD_SUM;
    end else if (frame_store[2] != FUNC_LED_WRITE) begin
      res.status    = ST_OTHER;
      res.func_code = frame_store[2];
    end else begin
      res.status    = ST_LED_WRITE;
      res.func_code = frame_store[2];
      res.led_index = frame_store[3];
      res.led_on    = (frame_store[4] != 8'd0);
    end
  end

  assign push      = accept && op == OP_IDLE;
  assign push_data = res;

endmodule

`default_nettype wire

// ===== hdl/lcfp_queue.sv =====
// lcfp_queue: short result queue between the front and back parts
// depends on lcfp_pkg for the result type
`default_nettype none

module lcfp_queue #(
  parameter int DEPTH = lcfp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lcfp_pkg::result_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output lcfp_pkg::result_t     pop_data
);
  import lcfp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcfp_back.sv =====
// lcfp_back: output register that drives result transactions from the queue
// depends on lcfp_pkg for the result type
`default_nettype none

module lcfp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              queue_not_empty,
  input  wire lcfp_pkg::result_t queue_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lcfp_pkg::result_t      out_data
);
  import lcfp_pkg::*;

  assign pop = queue_not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= queue_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/led_command_frame_parser_top.sv =====
// led_command_frame_parser_top: idle-delimited command frame parser with xor checksum
// depends on lcfp_pkg, lcfp_front, lcfp_queue, lcfp_back
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata rx_byte, tuser op
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata func_code/led_index/led_on,
//                                             tuser status
//
// one transaction per cycle on the input; a byte event is absorbed in the cycle it is taken
// an idle event's result is stored in the queue and then registered in the output reg
// input stalls only when the result queue is full; bytes stall too in that case
// sync reset clears the byte count, queue pointers and output valid; store is not cleared
`default_nettype none

module led_command_frame_parser_top #(
  parameter int QUEUE_DEPTH = lcfp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] func_code, [15:8] led_index,
                                           // [16] led_on, [23:17] zero
  output logic [2:0]       m_axis_tuser    // [2:0] status
);
  import lcfp_pkg::*;

  logic    queue_full;
  logic    push;
  result_t push_data;
  logic    pop;
  logic    queue_not_empty;
  result_t queue_data;
  result_t out_data;

  lcfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser),
    .rx_byte    (s_axis_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  lcfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .pop_data  (queue_data)
  );

  lcfp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (queue_not_empty),
    .queue_data      (queue_data),
    .pop             (pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_data        (out_data)
  );

  assign m_axis_tdata = {7'd0, out_data.led_on, out_data.led_index, out_data.func_code};
  assign m_axis_tuser = out_data.status;

endmodule

`default_nettype wire

// ===== verif/lcfp_checker.sv =====
// lcfp_checker: watches both stream channels of the led command frame parser
// predicts the verdict of every frame and compares it with each output transaction
// depends on lcfp_pkg
`timescale 1ns / 1ps

module lcfp_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_data,
  input  wire logic        in_op,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [23:0] out_data,
  input  wire logic [2:0]  out_status,
  output int               errors,
  output int               pending
);
  import lcfp_pkg::*;

  logic [2:0] held;
  logic [7:0] frame [FRAME_LEN];
  result_t    verdicts [$];
  int         misses;

  initial begin
    held    = '0;
    misses  = 0;
    errors  = 0;
    pending = 0;
  end

  function automatic result_t judge_frame();
    result_t    r;
    logic [7:0] sum;
    r = '0;
    if (held != FRAME_LEN) begin
      r.status = ST_BAD_LEN;
    end else if (frame[0] != HDR_FIRST || frame[1] != HDR_SECOND) begin
      r.status = ST_BAD_HDR;
    end else begin
      sum = frame[0] ^ frame[1] ^ frame[2] ^ frame[3] ^ frame[4];
      if (sum != frame[5]) begin
        r.status = ST_BAD_SUM;
      end else if (frame[2] != FUNC_LED_WRITE) begin
        r.status    = ST_OTHER;
        r.func_code = frame[2];
      end else begin
        r.status    = ST_LED_WRITE;
        r.func_code = frame[2];
        r.led_index = frame[3];
        r.led_on    = (frame[4] != 8'h00);
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    misses++;
    if (misses <= 10)
      $display("mismatch %s: expected %0h got %0h at %0t", field, want, got, $realtime);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      held = '0;
      verdicts.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_op == OP_BYTE) begin
          if (held < FRAME_LEN) begin
            frame[held] = in_data;
            held = held + 3'd1;
          end
        end else begin
          verdicts.push_back(judge_frame());
          held = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (verdicts.size() == 0) begin
          note_mismatch("result with none pending", 32'd0, 32'({out_status, out_data}));
        end else begin
          want = verdicts.pop_front();
          if (out_status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(out_status));
          if (out_data[7:0] !== want.func_code)
            note_mismatch("func_code", 32'(want.func_code), 32'(out_data[7:0]));
          if (out_data[15:8] !== want.led_index)
            note_mismatch("led_index", 32'(want.led_index), 32'(out_data[15:8]));
          if (out_data[16] !== want.led_on)
            note_mismatch("led_on", 32'(want.led_on), 32'(out_data[16]));
          if (out_data[23:17] !== 7'd0)
            note_mismatch("tdata padding", 32'd0, 32'(out_data[23:17]));
        end
      end
    end
    errors  <= misses;
    pending <= verdicts.size();
  end

endmodule

// ===== verif/testbench.sv =====
// testbench: drives received bytes and idle events into the led command frame parser
// depends on lcfp_pkg, led_command_frame_parser_top and lcfp_checker
`timescale 1ns / 1ps

module testbench;
  import lcfp_pkg::*;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_op    = OP_BYTE;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [23:0] m_data;
  logic [2:0]  m_status;
  int          errors;
  int          pending;

  logic        calm = 1'b0;
  logic [7:0]  frame_q [$];
  int          sent = 0;

  always #10 clk = ~clk;

  led_command_frame_parser_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_op),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_status)
  );

  lcfp_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_valid),
    .in_ready   (s_ready),
    .in_data    (s_data),
    .in_op      (s_op),
    .out_valid  (m_valid),
    .out_ready  (m_ready),
    .out_data   (m_data),
    .out_status (m_status),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (calm) m_ready <= 1'b1;
    else m_ready <= ($urandom_range(99) >= 10);
  end

  task automatic send_event(input logic op, input logic [7:0] b);
    s_valid <= 1'b1;
    s_op    <= op;
    s_data  <= b;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    if (!calm && $urandom_range(99) < 10) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] idle_byte);
    sent += frame_q.size() + 1;
    foreach (frame_q[i]) send_event(OP_BYTE, frame_q[i]);
    send_event(OP_IDLE, idle_byte);
  endtask

  task automatic load_led(input logic [7:0] func, input logic [7:0] idx,
                          input logic [7:0] cmd);
    frame_q.delete();
    frame_q.push_back(HDR_FIRST);
    frame_q.push_back(HDR_SECOND);
    frame_q.push_back(func);
    frame_q.push_back(idx);
    frame_q.push_back(cmd);
    frame_q.push_back(HDR_FIRST ^ HDR_SECOND ^ func ^ idx ^ cmd);
  endtask

  task automatic load_random_good();
    logic [7:0] func;
    logic [7:0] idx;
    logic [7:0] cmd;
    func = ($urandom_range(1) == 1) ? FUNC_LED_WRITE : 8'($urandom);
    idx  = 8'($urandom);
    cmd  = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
    load_led(func, idx, cmd);
  endtask

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int         frame_no;
    int         kind;
    int         len;
    logic [7:0] b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty frame, the byte on the idle event is ignored
    frame_q.delete();
    send_frame(8'hFF);
    // led write followed by one dropped byte
    load_led(FUNC_LED_WRITE, 8'hFF, 8'h01);
    frame_q.push_back(8'h00);
    send_frame(8'h00);
    // other function
    load_led(8'hFF, 8'h00, 8'h00);
    send_frame(8'hA5);
    // bad header
    load_led(FUNC_LED_WRITE, 8'h01, 8'h00);
    frame_q[0] = 8'h54;
    send_frame(8'h5A);
    // bad checksum
    load_led(FUNC_LED_WRITE, 8'h80, 8'hFE);
    frame_q[5] = frame_q[5] ^ 8'h80;
    send_frame(8'h00);

    frame_no = 0;
    while (sent < 1800) begin
      frame_no++;
      calm = (frame_no >= 150 && frame_no < 190);
      if (frame_no == 100) begin
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 60) begin
        load_random_good();
      end else if (kind < 75) begin
        load_random_good();
        b = 8'h01 << $urandom_range(7);
        frame_q[5] = frame_q[5] ^ b;
      end else if (kind < 85) begin
        load_random_good();
        b = 8'h01 << $urandom_range(7);
        len = $urandom_range(1);
        frame_q[len] = frame_q[len] ^ b;
      end else if (kind < 95) begin
        load_random_good();
        if ($urandom_range(1) == 1) begin
          len = $urandom_range(FRAME_LEN - 1);
          while (frame_q.size() > len) void'(frame_q.pop_back());
        end else begin
          repeat ($urandom_range(3, 1)) frame_q.push_back(8'($urandom));
        end
      end else begin
        frame_q.delete();
        repeat ($urandom_range(8)) frame_q.push_back(8'($urandom));
      end
      send_frame(8'($urandom));
    end
    calm = 1'b0;

    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lcfp_pkg.sv
hdl/lcfp_front.sv
hdl/lcfp_queue.sv
hdl/lcfp_back.sv
hdl/led_command_frame_parser_top.sv
verif/lcfp_checker.sv
verif/testbench.sv
